// ===== src/hsbc_pkg.sv =====
`timescale 1ns / 1ps

package hsbc_pkg;

    localparam int unsigned CODE_W   = 12;
    localparam int unsigned ENC_W    = 13;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned SYN_W    = 4;
    localparam int unsigned STAT_W   = 2;
    localparam int unsigned IN_W     = 24;
    localparam int unsigned OUT_W    = 32;
    localparam int unsigned USER_W   = 2;

    localparam logic [CODE_W-1:0] CHK1_MASK = 12'h554;
    localparam logic [CODE_W-1:0] CHK2_MASK = 12'h664;
    localparam logic [CODE_W-1:0] CHK3_MASK = 12'h870;
    localparam logic [CODE_W-1:0] CHK4_MASK = 12'hF00;

    localparam logic FUNC_ENCODE = 1'b0;
    localparam logic FUNC_DECODE = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_CORRECTED = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNCORR    = 2'd2;

    localparam logic [SYN_W-1:0] SYN_NONE     = 4'd0;
    localparam logic [SYN_W-1:0] SYN_LAST_POS = 4'd12;

    function automatic logic [CODE_W-1:0] hsbc_spread(input logic [BYTE_W-1:0] d);
        return {d[7:4], 1'b0, d[3:1], 1'b0, d[0], 2'b00};
    endfunction

    function automatic logic [BYTE_W-1:0] hsbc_gather(input logic [CODE_W-1:0] w);
        return {w[11:8], w[6:4], w[2]};
    endfunction

    function automatic logic [SYN_W-1:0] hsbc_checks(input logic [CODE_W-1:0] w);
        return {^(w & CHK4_MASK), ^(w & CHK3_MASK), ^(w & CHK2_MASK), ^(w & CHK1_MASK)};
    endfunction

endpackage

// ===== src/hamming_secded_byte_codec.sv =====
`timescale 1ns / 1ps
// byte sec-ded hamming codec, 8 data bits in a 13 bit code word
// input channel s_axis: tuser selects the operation (0 encode, 1 decode),
//   tdata carries the byte to encode and the received code word
// output channel m_axis: tdata carries encoded word, decoded byte and
//   syndrome, tuser carries the status (ok, corrected, uncorrectable)
// encode fills only the encoded word; decode fills byte, syndrome, status
// decode flips the bit named by a syndrome of 1 to 12 and checks the overall
//   parity bit; syndromes 13 to 15 pass the data through as uncorrectable
// each word passes an input register and then a result register, with
//   the xor trees between them
// throughput: one word per clock while m_axis_tready is high, set by the two-stage register pipeline
// when m_axis_tready is low the result register holds its word and the
//   input register still fills; s_axis_tready falls once both are full
// reset clears both valid flags, no word is in flight afterwards

module hamming_secded_byte_codec (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [hsbc_pkg::IN_W-1:0]     s_axis_tdata,  // data_byte, code_word
    input  logic                          s_axis_tuser,  // func
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [hsbc_pkg::OUT_W-1:0]    m_axis_tdata,  // encoded_word, decoded_byte, syndrome
    output logic [hsbc_pkg::USER_W-1:0]   m_axis_tuser   // status
);
    import hsbc_pkg::*;

    logic                r_in_vld;
    logic                r_func;
    logic [BYTE_W-1:0]   r_data_byte;
    logic [15:0]         r_code_word;

    logic                r_out_vld;
    logic [ENC_W-1:0]    r_enc;
    logic [BYTE_W-1:0]   r_dec;
    logic [SYN_W-1:0]    r_syn;
    logic [STAT_W-1:0]   r_stat;

    logic                adv_out;
    logic                adv_in;

    logic [CODE_W-1:0]   enc_base;
    logic [SYN_W-1:0]    enc_chk;
    logic [CODE_W-1:0]   enc_w;
    logic [CODE_W-1:0]   rx_w;
    logic [SYN_W-1:0]    rx_got;
    logic [SYN_W-1:0]    rx_syn;
    logic [CODE_W-1:0]   flip_vec;
    logic [CODE_W-1:0]   fixed_w;

    logic [ENC_W-1:0]    n_enc;
    logic [BYTE_W-1:0]   n_dec;
    logic [SYN_W-1:0]    n_syn;
    logic [STAT_W-1:0]   n_stat;

    assign adv_out       = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || adv_out;
    assign adv_in        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (adv_in) begin
                r_in_vld <= 1'b1;
            end else if (adv_out) begin
                r_in_vld <= 1'b0;
            end
            if (adv_out) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_in) begin
            r_func      <= s_axis_tuser;
            r_data_byte <= s_axis_tdata[7:0];
            r_code_word <= s_axis_tdata[23:8];
        end
        if (adv_out) begin
            r_enc  <= n_enc;
            r_dec  <= n_dec;
            r_syn  <= n_syn;
            r_stat <= n_stat;
        end
    end

    always_comb begin
        enc_base = hsbc_spread(r_data_byte);
        enc_chk  = hsbc_checks(enc_base);
        enc_w    = enc_base | {4'b0000, enc_chk[3], 3'b000, enc_chk[2], 1'b0, enc_chk[1:0]};

        rx_w     = r_code_word[CODE_W-1:0];
        rx_got   = {rx_w[7], rx_w[3], rx_w[1], rx_w[0]};
        rx_syn   = hsbc_checks(rx_w) ^ rx_got;
        for (int i = 0; i < CODE_W; i++) begin
            flip_vec[i] = (rx_syn == SYN_W'(i + 1));
        end
        fixed_w  = rx_w ^ flip_vec;

        n_enc  = '0;
        n_dec  = '0;
        n_syn  = '0;
        n_stat = ST_OK;
        if (r_func == FUNC_ENCODE) begin
            n_enc = {^enc_w, enc_w};
        end else begin
            n_syn = rx_syn;
            n_dec = hsbc_gather(fixed_w);
            if (rx_syn == SYN_NONE) begin
                n_stat = ST_OK;
            end else if (rx_syn <= SYN_LAST_POS) begin
                n_stat = ((^fixed_w) == r_code_word[CODE_W]) ? ST_CORRECTED : ST_UNCORR;
            end else begin
                n_stat = ST_UNCORR;
            end
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{(OUT_W - ENC_W - BYTE_W - SYN_W){1'b0}}, r_syn, r_dec, r_enc};
    assign m_axis_tuser  = r_stat;

endmodule

// ===== src/hsbc_checker.sv =====
`timescale 1ns / 1ps

module hsbc_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [hsbc_pkg::OUT_W-1:0]    m_axis_tdata,
    input  logic [hsbc_pkg::USER_W-1:0]   m_axis_tuser
);
    import hsbc_pkg::*;

    // status and syndrome agree: zero syndrome iff no error
    a_stat_syn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tuser == ST_OK) == (m_axis_tdata[24:21] == SYN_NONE)))
        else $error("status and syndrome disagree");

    a_stat_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == ST_OK || m_axis_tuser == ST_CORRECTED
                           || m_axis_tuser == ST_UNCORR))
        else $error("status code out of range");

    // decode results with a status other than ok never carry an encoded word
    a_dec_no_enc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_OK) |-> (m_axis_tdata[12:0] == '0))
        else $error("encoded word set on decode word");

    // a nonzero encoded word comes with a clear decoded byte and an ok status
    a_enc_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[12:0] != '0)
            |-> (m_axis_tdata[20:13] == '0 && m_axis_tuser == ST_OK))
        else $error("decode fields set on encode word");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready)
            |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled output word changed");

endmodule

bind hamming_secded_byte_codec hsbc_checker u_hsbc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import hsbc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 100000;
    localparam int unsigned RANDOM_WORDS = 900;

    typedef struct packed {
        logic [ENC_W-1:0]  enc;
        logic [BYTE_W-1:0] dec;
        logic [SYN_W-1:0]  syn;
        logic [STAT_W-1:0] st;
    } t_codec_result;

    class codec_scoreboard;
        t_codec_result pending[$];
        int unsigned   fails = 0;

        // check k covers every non-power-of-two position whose index has bit k set
        function logic [SYN_W-1:0] hamming_checks(logic [CODE_W-1:0] w);
            logic [SYN_W-1:0] c;
            c = '0;
            for (int b = 0; b < CODE_W; b++) begin
                if (((b + 1) & b) != 0) begin
                    for (int k = 0; k < SYN_W; k++) begin
                        if (((b + 1) >> k) & 1)
                            c[k] ^= w[b];
                    end
                end
            end
            return c;
        endfunction

        function logic [BYTE_W-1:0] data_bits_of(logic [CODE_W-1:0] w);
            logic [BYTE_W-1:0] d;
            int                idx;
            d = '0;
            idx = 0;
            for (int b = 0; b < CODE_W; b++) begin
                if (((b + 1) & b) != 0) begin
                    d[idx] = w[b];
                    idx++;
                end
            end
            return d;
        endfunction

        function logic [ENC_W-1:0] encode_byte(logic [BYTE_W-1:0] d);
            logic [ENC_W-1:0] w;
            logic [SYN_W-1:0] c;
            int               idx;
            w = '0;
            idx = 0;
            for (int b = 0; b < CODE_W; b++) begin
                if (((b + 1) & b) != 0) begin
                    w[b] = d[idx];
                    idx++;
                end
            end
            c = hamming_checks(w[CODE_W-1:0]);
            w[0] = c[0];
            w[1] = c[1];
            w[3] = c[2];
            w[7] = c[3];
            w[12] = ^w[CODE_W-1:0];
            return w;
        endfunction

        function t_codec_result decode_word(logic [15:0] w);
            t_codec_result     r;
            logic [CODE_W-1:0] body;
            r = '0;
            body = w[CODE_W-1:0];
            r.syn = hamming_checks(body) ^ {w[7], w[3], w[1], w[0]};
            if (r.syn == SYN_NONE) begin
                r.st = ST_OK;
            end else if (r.syn <= SYN_LAST_POS) begin
                body = body ^ (12'b1 << (r.syn - 1));
                r.st = (^body == w[12]) ? ST_CORRECTED : ST_UNCORR;
            end else begin
                r.st = ST_UNCORR;
            end
            r.dec = data_bits_of(body);
            return r;
        endfunction

        function void note_input(logic f, logic [BYTE_W-1:0] b, logic [15:0] w);
            t_codec_result r;
            if (f == FUNC_ENCODE) begin
                r = '0;
                r.enc = encode_byte(b);
            end else begin
                r = decode_word(w);
            end
            pending.push_back(r);
        endfunction

        function void check_output(logic [OUT_W-1:0] tdata, logic [USER_W-1:0] tuser);
            t_codec_result exp_r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word, got tdata %h tuser %h", $time, tdata, tuser);
                fails++;
                return;
            end
            exp_r = pending.pop_front();
            if (tdata[12:0] !== exp_r.enc) begin
                $display("%0t: encoded_word expected %h got %h", $time, exp_r.enc, tdata[12:0]);
                fails++;
            end
            if (tdata[20:13] !== exp_r.dec) begin
                $display("%0t: decoded_byte expected %h got %h", $time, exp_r.dec, tdata[20:13]);
                fails++;
            end
            if (tdata[24:21] !== exp_r.syn) begin
                $display("%0t: syndrome expected %h got %h", $time, exp_r.syn, tdata[24:21]);
                fails++;
            end
            if (tuser !== exp_r.st) begin
                $display("%0t: status expected %h got %h", $time, exp_r.st, tuser);
                fails++;
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [IN_W-1:0]     s_axis_tdata = '0;   // data_byte, code_word
    logic                s_axis_tuser = 1'b0; // func
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_W-1:0]    m_axis_tdata;        // encoded_word, decoded_byte, syndrome
    logic [USER_W-1:0]   m_axis_tuser;        // status

    codec_scoreboard     sb = new();
    bit                  calm = 1'b0;
    int unsigned         cycle_count = 0;

    hamming_secded_byte_codec dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic bit take_break();
        return !calm && ($urandom_range(99) < 7);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !take_break();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_output(m_axis_tdata, m_axis_tuser);
    end

    task automatic send_word(input logic f, input logic [BYTE_W-1:0] b, input logic [15:0] w);
        while (take_break()) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {w, b};
        s_axis_tuser  <= f;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        sb.note_input(f, b, w);
    endtask

    task automatic send_decode(input logic [15:0] w);
        send_word(FUNC_DECODE, 8'($urandom), w);
    endtask

    initial begin
        logic [15:0]       cw;
        logic [BYTE_W-1:0] d;
        int                kind;
        int                p1;
        int                p2;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // encode extremes and alternating patterns
        send_word(FUNC_ENCODE, 8'h00, 16'hFFFF);
        send_word(FUNC_ENCODE, 8'hFF, 16'h0000);
        send_word(FUNC_ENCODE, 8'hA5, 16'h1234);
        send_word(FUNC_ENCODE, 8'h5A, 16'hEDCB);
        // clean words and an all-ones word, top bits ignored
        send_decode({3'b111, sb.encode_byte(8'hFF)});
        send_decode(16'h0000);
        send_decode(16'hFFFF);
        // single errors at each hamming position
        cw = {3'b000, sb.encode_byte(8'h3C)};
        for (int p = 0; p < CODE_W; p++)
            send_decode(cw ^ (16'h1 << p));
        // overall parity bit alone, double error
        send_decode(cw ^ 16'h1000);
        send_decode(cw ^ 16'h0041);
        // syndromes that name no position
        send_decode(cw ^ 16'h0089);
        send_decode(cw ^ 16'h008A);
        send_decode(cw ^ 16'h008B);

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            calm = (i >= 350 && i < 550);
            d = 8'($urandom);
            kind = $urandom_range(99);
            if (kind < 30) begin
                send_word(FUNC_ENCODE, d, 16'($urandom));
            end else begin
                cw = {3'($urandom), sb.encode_byte(d)};
                p1 = $urandom_range(12);
                p2 = (p1 + 1 + $urandom_range(11)) % 13;
                if (kind < 48)
                    send_decode(cw);
                else if (kind < 76)
                    send_decode(cw ^ (16'h1 << p1));
                else if (kind < 90)
                    send_decode(cw ^ (16'h1 << p1) ^ (16'h1 << p2));
                else
                    send_decode(16'($urandom));
            end
        end
        calm = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (sb.fails == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
